### rtl/ebcv_pkg.sv
`timescale 1ns / 1ps
package ebcv_pkg;

  localparam int NBANDS = 8;
  localparam int NROWS = 17;
  localparam int SHIFT_ROW_ZERO = 12;
  localparam int SHIFT_ROW_CAP = 16;

  typedef enum logic [1:0] {
    SH_11 = 2'd0,
    SH_16 = 2'd1,
    SH_20 = 2'd2
  } shift_t;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_FORMANT  = 3'd1,
    REG_RESON    = 3'd2,
    REG_ATTACK   = 3'd3,
    REG_RELEASE  = 3'd4,
    REG_NOISE    = 3'd5,
    REG_GATE     = 3'd6
  } reg_index_t;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] RATIO_CAP_Q16 = 64'd81028;
  localparam logic [63:0] COEF_CAP_Q16 = 64'd62259;

  localparam logic [12*NBANDS-1:0] CENTRE_HZ = {
    12'd2750, 12'd2050, 12'd1450, 12'd950, 12'd600, 12'd360, 12'd210, 12'd120};

  // 2^(k/12) in q16 for k = -12..3
  localparam logic [17*16-1:0] SEMITONE_Q16 = {
    17'd77936, 17'd73562, 17'd69433, 17'd65536, 17'd61858, 17'd58386, 17'd55109,
    17'd52016, 17'd49097, 17'd46341, 17'd43740, 17'd41285, 17'd38968, 17'd36781,
    17'd34716, 17'd32768};

  function automatic logic [128*16-1:0] build_damp();
    logic [128*16-1:0] t;
    t = '0;
    for (int r = 0; r < 128; r++) begin
      t[r*16 +: 16] = 16'(14418 + ((127 - r) * 65536 + 90) / 180);
    end
    return t;
  endfunction

  function automatic logic [128*16-1:0] build_attack();
    logic [128*16-1:0] t;
    t = '0;
    for (int r = 0; r < 128; r++) begin
      t[r*16 +: 16] = 16'(131 + (r * 65536 + 1250) / 2500);
    end
    return t;
  endfunction

  function automatic logic [128*16-1:0] build_release();
    logic [128*16-1:0] t;
    t = '0;
    for (int r = 0; r < 128; r++) begin
      t[r*16 +: 16] = 16'(13 + (r * 65536 + 6000) / 12000);
    end
    return t;
  endfunction

  function automatic logic [128*16-1:0] build_gain();
    logic [128*16-1:0] t;
    t = '0;
    for (int r = 0; r < 128; r++) begin
      t[r*16 +: 16] = 16'((r * 65536 + 635) / 1270);
    end
    return t;
  endfunction

  function automatic logic [128*16-1:0] build_scale();
    logic [128*16-1:0] t;
    t = '0;
    for (int r = 0; r < 128; r++) begin
      t[r*16 +: 16] = 16'(22282 - (r * 262144 + 1587) / 3175);
    end
    return t;
  endfunction

  function automatic logic [128*20-1:0] build_gate();
    logic [128*20-1:0] t;
    t = '0;
    for (int r = 0; r < 128; r++) begin
      t[r*20 +: 20] = 20'(((r * 1048576) + 127) / 254);
    end
    return t;
  endfunction

  localparam logic [128*16-1:0] DAMP_LUT = build_damp();
  localparam logic [128*16-1:0] ATTACK_LUT = build_attack();
  localparam logic [128*16-1:0] RELEASE_LUT = build_release();
  localparam logic [128*16-1:0] GAIN_LUT = build_gain();
  localparam logic [128*16-1:0] SCALE_LUT = build_scale();
  localparam logic [128*20-1:0] GATE_LUT = build_gate();

endpackage

### rtl/ebcv_mul.sv
`timescale 1ns / 1ps
module ebcv_mul
  import ebcv_pkg::*;
#(
  parameter int MA = 24,
  parameter int MB = 31
) (
  input  logic signed [MA-1:0]    a,
  input  logic signed [MB-1:0]    b,
  input  shift_t                  sh,
  output logic signed [MA+MB-1:0] p
);

  logic signed [MA+MB-1:0] prod;

  assign prod = MA'(a) * MB'(b) ;

  // floor shift of the full product
  always_comb begin
    unique case (sh)
      SH_11:   p = prod >>> 11;
      SH_16:   p = prod >>> 16;
      SH_20:   p = prod >>> 20;
      default: p = prod >>> 16;
    endcase
  end

endmodule

### rtl/ebcv_lcg.sv
`timescale 1ns / 1ps
module ebcv_lcg
  import ebcv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  output logic [31:0] value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= 32'd1;
    end else if (step) begin
      value <= value * LCG_MUL + LCG_ADD;
    end
  end

endmodule

### rtl/eight_band_channel_vocoder_top.sv
`timescale 1ns / 1ps
// channel  | dir | fields (low bit up)                             | beat rule
// s_axis   | in  | tdata: carrier_sample[15:0], modulator_sample[31:16] | tvalid & tready
// m_axis   | out | tdata: out_sample[15:0]                         | tvalid & tready
// cfg      | in  | cfg_index selects register, cfg_data[6:0]       | cfg_we
//
// enabled: from input beat to output beat the sequencer runs lcg step, noise multiply,
// 8 bands of 8 steps each through the one shared multiplier, output scaling, writeback
// disabled: carrier passes unchanged through the writeback state, no state moves
// reset (rst, synchronous) clears filters and envelopes, seeds the noise generator with 1
// a held output beat stalls the sequencer; the input is taken only when idle
module eight_band_channel_vocoder_top
  import ebcv_pkg::*;
#(
  parameter int SAMPLE_RATE_HZ = 22050,
  parameter int STATE_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // carrier_sample[15:0], modulator_sample[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_sample[15:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int SW = STATE_WIDTH;
  localparam int EW = SW + 4;                 // filter input / high-pass width
  localparam int AW = 2 * SW - 17;            // band sum width
  localparam int MA = SW;                     // multiplier port a
  localparam int MB = (AW > EW) ? AW : EW;    // multiplier port b
  localparam int WW = MB + 2;                 // working sum width
  localparam logic signed [WW-1:0] SMAX = (WW'(1) <<< (SW - 1)) - WW'(1);
  localparam logic signed [WW-1:0] SMIN = -SMAX - WW'(1);
  localparam logic signed [WW-1:0] ONE = WW'(1) <<< 20;
  localparam logic [63:0] RATE_Q16 = 64'(SAMPLE_RATE_HZ) << 16;

  // band coefficient rom, one row per clamped formant shift
  function automatic logic [NROWS*NBANDS*16-1:0] build_coef();
    logic [NROWS*NBANDS*16-1:0] t;
    logic [63:0] ratio, x, x2, tt, s, c;
    t = '0;
    for (int r = 0; r < NROWS; r++) begin
      for (int b = 0; b < NBANDS; b++) begin
        ratio = (r == SHIFT_ROW_CAP) ? RATIO_CAP_Q16 : 64'(SEMITONE_Q16[r*17 +: 17]);
        x = 64'(CENTRE_HZ[b*12 +: 12]) * ratio * PI_Q30 / RATE_Q16;
        x2 = (x * x) >> 30;
        tt = ONE_Q30;
        tt = ONE_Q30 - ((x2 * tt) >> 30) / 72;
        tt = ONE_Q30 - ((x2 * tt) >> 30) / 42;
        tt = ONE_Q30 - ((x2 * tt) >> 30) / 20;
        tt = ONE_Q30 - ((x2 * tt) >> 30) / 6;
        s = (x * tt) >> 30;
        c = (s + 64'd8192) >> 14;
        t[(r*NBANDS+b)*16 +: 16] = (c > COEF_CAP_Q16) ? 16'(COEF_CAP_Q16) : 16'(c);
      end
    end
    return t;
  endfunction

  localparam logic [NROWS*NBANDS*16-1:0] COEF_ROM = build_coef();

  function automatic logic signed [SW-1:0] sat(input logic signed [WW-1:0] v);
    if (v > SMAX) return SW'(SMAX);
    if (v < SMIN) return SW'(SMIN);
    return SW'(v);
  endfunction

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_NOISE = 13'b0000000000010,
    ST_NMUL  = 13'b0000000000100,
    ST_CLOW  = 13'b0000000001000,
    ST_CHI   = 13'b0000000010000,
    ST_CBND  = 13'b0000000100000,
    ST_MLOW  = 13'b0000001000000,
    ST_MHI   = 13'b0000010000000,
    ST_MBND  = 13'b0000100000000,
    ST_ENV   = 13'b0001000000000,
    ST_ACC   = 13'b0010000000000,
    ST_SCALE = 13'b0100000000000,
    ST_WB    = 13'b1000000000000
  } state_t;

  state_t state;

  // configuration
  logic       enable;
  logic [4:0] coef_row;
  logic [6:0] resonance, attack_setting, release_setting, noise_level, gate_level;

  // band state
  logic signed [SW-1:0] cl [NBANDS];
  logic signed [SW-1:0] cb [NBANDS];
  logic signed [SW-1:0] ml [NBANDS];
  logic signed [SW-1:0] mb [NBANDS];
  logic signed [SW-1:0] env [NBANDS];

  logic signed [15:0]   cs, ms;
  logic signed [EW-1:0] xc, hi;
  logic signed [AW-1:0] acc;
  logic [2:0]           band;
  logic [15:0]          res;

  logic [31:0] lcg;
  logic        lcg_step;

  logic signed [MA-1:0]    mul_a;
  logic signed [MB-1:0]    mul_b;
  shift_t                  mul_sh;
  logic signed [MA+MB-1:0] mul_p;
  logic signed [WW-1:0]    pw;

  logic [15:0]          f, damp, atk, rel, gain, scale;
  logic [19:0]          gate;
  logic [11:0]          gate_base;
  logic signed [WW-1:0] xm, target, diff, y, sum;
  logic [35:0]          ymag, mag;
  logic                 out_free;

  // gate entries are 20 bits wide: base = level * 20
  assign gate_base = 12'({gate_level, 4'd0}) + 12'({gate_level, 2'd0});

  assign f     = COEF_ROM[{coef_row, band, 4'd0} +: 16];
  assign damp  = DAMP_LUT[{resonance, 4'd0} +: 16];
  assign atk   = ATTACK_LUT[{attack_setting, 4'd0} +: 16];
  assign rel   = RELEASE_LUT[{release_setting, 4'd0} +: 16];
  assign gain  = GAIN_LUT[{noise_level, 4'd0} +: 16];
  assign scale = SCALE_LUT[{resonance, 4'd0} +: 16];
  assign gate  = GATE_LUT[gate_base +: 20];

  assign xm = WW'(ms) <<< 5;
  assign lcg_step = (state == ST_NOISE);
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  ebcv_lcg u_lcg (
    .clk   (clk),
    .rst   (rst),
    .step  (lcg_step),
    .value (lcg)
  );

  ebcv_mul #(.MA(MA), .MB(MB)) u_mul (
    .a  (mul_a),
    .b  (mul_b),
    .sh (mul_sh),
    .p  (mul_p)
  );

  assign pw = WW'(mul_p);

  // envelope target: saturated magnitude of the modulator band
  always_comb begin
    target = (mb[band] < 0) ? -WW'(mb[band]) : WW'(mb[band]);
    target = WW'(sat(target));
    diff = target - WW'(env[band]);
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a  = MA'($signed({1'b0, f}));
    mul_b  = MB'(cb[band]);
    mul_sh = SH_16;
    unique case (state)
      ST_NMUL: begin
        mul_a  = MA'($signed({1'b0, gain}));
        mul_b  = MB'($signed({~lcg[31], lcg[30:16]}));
        mul_sh = SH_11;
      end
      ST_CHI:  mul_a = MA'($signed({1'b0, damp}));
      ST_CBND: mul_b = MB'(hi);
      ST_MLOW: mul_b = MB'(mb[band]);
      ST_MHI: begin
        mul_a = MA'($signed({1'b0, damp}));
        mul_b = MB'(mb[band]);
      end
      ST_MBND: mul_b = MB'(hi);
      ST_ENV: begin
        mul_a = (target > WW'(env[band])) ? MA'($signed({1'b0, atk}))
                                          : MA'($signed({1'b0, rel}));
        mul_b = MB'(diff);
      end
      ST_ACC: begin
        mul_a  = MA'(env[band]);
        mul_sh = SH_20;
      end
      ST_SCALE: begin
        mul_a = MA'($signed({1'b0, scale}));
        mul_b = MB'(acc);
      end
      default: ;
    endcase
  end

  // output scaling: clamp to +-1, then times 32767 with truncation to zero
  always_comb begin
    y = pw;
    if (y > ONE) y = ONE;
    if (y < -ONE) y = -ONE;
    ymag = (y < 0) ? 36'(-y) : 36'(y);
    mag = ((ymag << 15) - ymag) >> 20;
    sum = WW'(acc) + pw;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b0;
      coef_row        <= 5'(SHIFT_ROW_ZERO);
      resonance       <= 7'd70;
      attack_setting  <= 7'd50;
      release_setting <= 7'd35;
      noise_level     <= 7'd10;
      gate_level      <= 7'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: enable <= cfg_data[0];
        REG_FORMANT: begin
          if ($signed(cfg_data[4:0]) < $signed(-5'sd12)) begin
            coef_row <= 5'd0;
          end else if ($signed(cfg_data[4:0]) > $signed(5'sd3)) begin
            coef_row <= 5'(SHIFT_ROW_CAP);
          end else begin
            coef_row <= cfg_data[4:0] + 5'(SHIFT_ROW_ZERO);
          end
        end
        REG_RESON:   resonance       <= cfg_data;
        REG_ATTACK:  attack_setting  <= cfg_data;
        REG_RELEASE: release_setting <= cfg_data;
        REG_NOISE:   noise_level     <= cfg_data;
        REG_GATE:    gate_level      <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      band     <= '0;
      m_tvalid <= 1'b0;
      acc      <= '0;
      for (int i = 0; i < NBANDS; i++) begin
        cl[i]  <= '0;
        cb[i]  <= '0;
        ml[i]  <= '0;
        mb[i]  <= '0;
        env[i] <= '0;
      end
    end else begin
      // writeback below owns the valid flag in its own state
      if (m_tvalid && m_tready && state != ST_WB) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cs   <= s_tdata[15:0];
            ms   <= s_tdata[31:16];
            res  <= s_tdata[15:0];
            band <= '0;
            acc  <= '0;
            state <= enable ? ST_NOISE : ST_WB;
          end
        end
        ST_NOISE: state <= ST_NMUL;
        ST_NMUL: begin
          xc    <= EW'((WW'(cs) <<< 5) + pw);
          state <= ST_CLOW;
        end
        ST_CLOW: begin
          cl[band] <= sat(WW'(cl[band]) + pw);
          state    <= ST_CHI;
        end
        ST_CHI: begin
          hi    <= EW'(WW'(xc) - WW'(cl[band]) - pw);
          state <= ST_CBND;
        end
        ST_CBND: begin
          cb[band] <= sat(WW'(cb[band]) + pw);
          state    <= ST_MLOW;
        end
        ST_MLOW: begin
          ml[band] <= sat(WW'(ml[band]) + pw);
          state    <= ST_MHI;
        end
        ST_MHI: begin
          hi    <= EW'(xm - WW'(ml[band]) - pw);
          state <= ST_MBND;
        end
        ST_MBND: begin
          mb[band] <= sat(WW'(mb[band]) + pw);
          state    <= ST_ENV;
        end
        ST_ENV: begin
          env[band] <= sat(WW'(env[band]) + pw);
          state     <= ST_ACC;
        end
        ST_ACC: begin
          // gate compares the envelope against the threshold
          if (WW'(env[band]) > $signed(WW'({1'b0, gate}))) acc <= AW'(sum);
          band  <= band + 3'd1;
          state <= (band == 3'(NBANDS - 1)) ? ST_SCALE : ST_CLOW;
        end
        ST_SCALE: begin
          res   <= (y < 0) ? 16'(-mag) : 16'(mag);
          state <= ST_WB;
        end
        ST_WB: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/ebcv_checker.sv
`timescale 1ns / 1ps
module ebcv_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a held output beat keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // busy right after an input beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // no output beat straight out of reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind eight_band_channel_vocoder_top ebcv_checker u_ebcv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### test/tb_eight_band_channel_vocoder_top.sv
`timescale 1ns / 1ps
module tb_eight_band_channel_vocoder_top;
  import ebcv_pkg::*;

  localparam int NB = 8;
  localparam int SW = 24;
  localparam int RATE_HZ = 22050;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // carrier_sample[15:0], modulator_sample[31:16]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // out_sample[15:0]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [6:0]  cfg_data;

  eight_band_channel_vocoder_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the block's registers and state
  logic              voc_on;
  logic signed [4:0] shift_semis;
  logic [6:0]        reson_knob, attack_knob, release_knob, noise_knob, gate_knob;
  longint            car_low[NB], car_band[NB], mod_low[NB], mod_band[NB], env_lvl[NB];
  logic [31:0]       lcg_state;
  longint unsigned   band_coef[NB];

  logic [15:0] out_queue[$];
  int          n_fail;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // floor shift for signed values
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip_state(longint v);
    longint hi;
    hi = (longint'(1) <<< (SW - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint unsigned sine_coef(longint unsigned hz, longint unsigned ratio);
    longint unsigned x, x2, t, s, c;
    x = hz * ratio * 64'd3373259426 / (longint'(RATE_HZ) << 16);
    x2 = (x * x) >> 30;
    t = 64'd1073741824;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 72;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    c = (s + 8192) >> 14;
    return c > 62259 ? 62259 : c;
  endfunction

  task automatic reload_band_coefs();
    int k;
    longint unsigned ratio;
    longint unsigned semis[16];
    longint unsigned centres[NB];
    semis = '{32768, 34716, 36781, 38968, 41285, 43740, 46341, 49097,
              52016, 55109, 58386, 61858, 65536, 69433, 73562, 77936};
    centres = '{120, 210, 360, 600, 950, 1450, 2050, 2750};
    k = shift_semis;
    if (k < -12) k = -12;
    ratio = k > 3 ? 81028 : semis[k + 12];
    for (int i = 0; i < NB; i++) band_coef[i] = sine_coef(centres[i], ratio);
  endtask

  task automatic model_reset();
    voc_on = 0; shift_semis = 0; reson_knob = 70; attack_knob = 50;
    release_knob = 35; noise_knob = 10; gate_knob = 4;
    for (int i = 0; i < NB; i++) begin
      car_low[i] = 0; car_band[i] = 0; mod_low[i] = 0; mod_band[i] = 0; env_lvl[i] = 0;
    end
    lcg_state = 1;
    reload_band_coefs();
  endtask

  function automatic logic [15:0] vocode_sample(logic [15:0] cs, logic [15:0] ms);
    longint car, modu, acc, y, hi, tgt, e, noise, mag;
    longint damp, atk, rel, gain, scale, gate, f;
    if (!voc_on) return cs;
    lcg_state = lcg_state * 32'd1664525 + 32'd1013904223;
    noise = longint'(lcg_state >> 16) - 32768;
    gain = (longint'(noise_knob) * 65536 + 635) / 1270;
    car = longint'($signed(cs)) * 32 + floor_shr(noise * gain, 11);
    modu = longint'($signed(ms)) * 32;
    damp = 14418 + ((127 - longint'(reson_knob)) * 65536 + 90) / 180;
    atk = 131 + (longint'(attack_knob) * 65536 + 1250) / 2500;
    rel = 13 + (longint'(release_knob) * 65536 + 6000) / 12000;
    gate = ((longint'(gate_knob) << 20) + 127) / 254;
    scale = 22282 - (longint'(reson_knob) * 262144 + 1587) / 3175;
    acc = 0;
    for (int i = 0; i < NB; i++) begin
      f = longint'(band_coef[i]);
      car_low[i] = clip_state(car_low[i] + floor_shr(f * car_band[i], 16));
      hi = car - car_low[i] - floor_shr(damp * car_band[i], 16);
      car_band[i] = clip_state(car_band[i] + floor_shr(f * hi, 16));
      mod_low[i] = clip_state(mod_low[i] + floor_shr(f * mod_band[i], 16));
      hi = modu - mod_low[i] - floor_shr(damp * mod_band[i], 16);
      mod_band[i] = clip_state(mod_band[i] + floor_shr(f * hi, 16));
      tgt = clip_state(mod_band[i] < 0 ? -mod_band[i] : mod_band[i]);
      e = env_lvl[i];
      e = clip_state(e + floor_shr((tgt > e ? atk : rel) * (tgt - e), 16));
      env_lvl[i] = e;
      if (e > gate) acc += floor_shr(car_band[i] * e, 20);
    end
    y = floor_shr(acc * scale, 16);
    if (y > (1 << 20)) y = 1 << 20;
    if (y < -(1 << 20)) y = -(1 << 20);
    mag = ((y < 0 ? -y : y) * 32767) >> 20;
    y = y < 0 ? -mag : mag;
    return y[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, $signed(got), $signed(want),
             $realtime);
    n_fail++;
  endtask

  // register write, mirrored into the predictor; only while idle
  task automatic write_reg(reg_index_t idx, logic [6:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      REG_ENABLE:  voc_on = val[0];
      REG_FORMANT: begin
        shift_semis = val[4:0];
        reload_band_coefs();
      end
      REG_RESON:   reson_knob = val;
      REG_ATTACK:  attack_knob = val;
      REG_RELEASE: release_knob = val;
      REG_NOISE:   noise_knob = val;
      REG_GATE:    gate_knob = val;
      default: ;
    endcase
  endtask

  // send one beat; burst gaps before it at random
  task automatic send_beat(logic [15:0] cs, logic [15:0] ms);
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {ms, cs};
    do @(posedge clk); while (!s_tready);
    out_queue.push_back(vocode_sample(cs, ms));
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (out_queue.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // receiver stall pattern: phases of always-ready, random half-ready and sparse-ready
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: m_tready <= 1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // output checker
  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (out_queue.size() == 0) begin
        report_mismatch("unexpected output beat", m_tdata, 16'h0000);
      end else begin
        want = out_queue.pop_front();
        if (m_tdata !== want) report_mismatch("out_sample", m_tdata, want);
      end
    end
  end

  typedef struct {
    logic [15:0] cs;
    logic [15:0] ms;
    logic        known;   // expected output typed in
    logic [15:0] want;
  } stim_row_t;

  // disabled rows pass the carrier; enabled rows use the predictor
  stim_row_t directed[] = '{
    '{16'h0000, 16'h0000, 1, 16'h0000},
    '{16'h7FFF, 16'h8000, 1, 16'h7FFF},
    '{16'h8000, 16'h7FFF, 1, 16'h8000},
    '{16'hFFFF, 16'h0001, 1, 16'hFFFF},
    '{16'h5555, 16'hAAAA, 1, 16'h5555},
    '{16'h7FFF, 16'h7FFF, 0, 16'h0},
    '{16'h8000, 16'h8000, 0, 16'h0},
    '{16'h7FFF, 16'h8000, 0, 16'h0},
    '{16'h8000, 16'h7FFF, 0, 16'h0},
    '{16'h0000, 16'h7FFF, 0, 16'h0},
    '{16'h7FFF, 16'h0000, 0, 16'h0},
    '{16'h1234, 16'hEDCB, 0, 16'h0}
  };

  logic [6:0] setting_sets[6][7] = '{
    '{1, 0,   0,   0,   0,   0,   0},
    '{1, 12,  127, 127, 127, 127, 127},
    '{1, 20,  70,  50,  35,  10,  4},   // shift -12
    '{1, 16,  0,   127, 0,   0,   0},   // shift -16 acts as -12
    '{1, 15,  127, 64,  90,  127, 30},  // above cap
    '{1, 3,   90,  20,  70,  40,  2}
  };

  initial begin
    n_fail = 0;
    rst = 1; s_tvalid = 0; s_tdata = '0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: first five disabled, rest enabled at reset settings
    foreach (directed[r]) begin
      if (r == 5) begin
        drain();
        write_reg(REG_ENABLE, 1);
      end
      if (directed[r].known && vocode_sample(directed[r].cs, directed[r].ms)
          !== directed[r].want)
        report_mismatch("typed row", vocode_sample(directed[r].cs, directed[r].ms),
                        directed[r].want);
      send_beat(directed[r].cs, directed[r].ms);
    end
    drain();
    // undefined register index is ignored
    cfg_we <= 1; cfg_index <= 3'd7; cfg_data <= 7'h7F;
    @(posedge clk);
    cfg_we <= 0;

    // random phases across settings, extremes included
    for (int p = 0; p < 8; p++) begin
      drain();
      for (int j = 0; j < 7; j++)
        write_reg(reg_index_t'(j), p < 6 ? setting_sets[p][j] :
                  (j == 0 ? 7'(p == 7) : 7'($urandom_range(0, 127))));
      for (int n = 0; n < 200; n++) begin
        logic [15:0] cs, ms;
        cs = $urandom;
        ms = $urandom;
        if ($urandom_range(0, 9) == 0) cs = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        if ($urandom_range(0, 9) == 0) ms = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        send_beat(cs, ms);
      end
    end
    drain();
    if (n_fail == 0 && out_queue.size() == 0) begin
      $display("PASS eight_band_channel_vocoder_top");
    end else begin
      $display("FAIL eight_band_channel_vocoder_top");
    end
    $finish;
  end

  // ~1650 beats, each a full band sweep plus stalls, comfortably under this
  initial begin
    #30ms;
    $display("FAIL eight_band_channel_vocoder_top");
    $finish;
  end

endmodule
